/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers included by the rmd_ctrl sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RMD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after its trigger.
`define RMD_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/rmd_pkg.sv */
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types, constants and round functions of the RIPEMD-160 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rmd_pkg;

   localparam int unsigned NumRounds = 80;
   localparam int unsigned NumWords  = 16;
   localparam logic [5:0]  LastByte  = 6'd63;
   localparam logic [5:0]  PadEnd    = 6'd56;
   localparam logic [2:0]  LastIdx   = 3'd4;
   localparam logic [6:0]  LastRound = 7'd79;

   localparam logic [31:0] InitH [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_of_digest;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_BYTE, ST_PRIME, ST_ROUND, ST_UPDATE, ST_OUT
   } state_type;

   // Source of the next byte written into the block buffer.
   typedef enum logic [2:0] {
      PH_DATA, PH_PAD, PH_ZERO, PH_LEN, PH_DONE
   } phase_type;

   typedef struct packed {
      logic       load;
      logic       put_byte;
      phase_type  byte_src;
      logic       latch_len;
      logic       init_work;
      logic       round_en;
      logic [6:0] round;
      logic [6:0] rd_round;
      logic       update;
      logic [2:0] out_idx;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic [5:0] bytes_in_block;
      logic       bytes_left_zero;
      logic       last_flag;
   } status_type;

   localparam logic [3:0] SelL [80] = '{
      0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
      7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
      3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
      1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
      4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
   localparam logic [3:0] SelR [80] = '{
      5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
      6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
      15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
      8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
      12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
   localparam logic [3:0] RotL [80] = '{
      11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
      7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
      11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
      11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
      9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
   localparam logic [3:0] RotR [80] = '{
      8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
      9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
      9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
      15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
      8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
   localparam logic [31:0] AddL [5] = '{
      32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
   localparam logic [31:0] AddR [5] = '{
      32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};

   // Table lookups; indexes past the last round read as zero.
   function automatic logic [3:0] sel_l(input logic [6:0] idx);
      sel_l = (idx < 7'(NumRounds)) ? SelL[idx] : 4'd0;
   endfunction

   function automatic logic [3:0] sel_r(input logic [6:0] idx);
      sel_r = (idx < 7'(NumRounds)) ? SelR[idx] : 4'd0;
   endfunction

   function automatic logic [3:0] rot_l(input logic [6:0] idx);
      rot_l = (idx < 7'(NumRounds)) ? RotL[idx] : 4'd0;
   endfunction

   function automatic logic [3:0] rot_r(input logic [6:0] idx);
      rot_r = (idx < 7'(NumRounds)) ? RotR[idx] : 4'd0;
   endfunction

   function automatic logic [31:0] add_l(input logic [2:0] g);
      add_l = (g <= LastIdx) ? AddL[g] : 32'd0;
   endfunction

   function automatic logic [31:0] add_r(input logic [2:0] g);
      add_r = (g <= LastIdx) ? AddR[g] : 32'd0;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [3:0] n);
      logic [63:0] dbl;
      dbl  = {v, v} << n;
      rotl = dbl[63:32];
   endfunction

   // The five boolean functions of the two lines.
   function automatic logic [31:0] mix(input logic [2:0] g, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z);
      unique case (g)
         3'd0:    mix = x ^ y ^ z;
         3'd1:    mix = (x & y) | (~x & z);
         3'd2:    mix = (x | ~y) ^ z;
         3'd3:    mix = (x & z) | (y & ~z);
         default: mix = x ^ (y | ~z);
      endcase
   endfunction

endpackage

`default_nettype wire

/* rtl/ripemd160_hash_engine.sv */
// A word is accepted in idle, then its valid bytes go into the block buffer one by one, and the
// engine returns to idle. Each full 64-byte block gets read priming, 80 rounds with both lines
// in parallel, and the chaining update. A new word is taken only in idle, once the previous word
// and any block it filled are done. The last word adds padding (one or two blocks) and five
// digest transfers. Synchronous active-high reset restores the initial chaining words.
// ----------------------------------------------------------------------------
// ripemd160_hash_engine
// RIPEMD-160 digest of a byte stream that arrives as packed 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module ripemd160_hash_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire rmd_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rmd_pkg::rsp_payload_type      rsp_data
);

   rmd_pkg::cmd_type    cmd;
   rmd_pkg::status_type status;
   logic [31:0]         digest_word;

   rmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rmd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .status      (status),
      .digest_word (digest_word)
   );

   // Result transfer payload.
   assign rsp_data.digest_word    = digest_word;
   assign rsp_data.word_index     = cmd.out_idx;
   assign rsp_data.last_of_digest = (cmd.out_idx == rmd_pkg::LastIdx);

endmodule

`default_nettype wire

/* rtl/rmd_datapath.sv */
// ----------------------------------------------------------------------------
// rmd_datapath
// Block buffer, byte counters, chaining words and the two round lines.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rmd_pkg::cmd_type         cmd,
   input  wire rmd_pkg::req_payload_type req_data,
   output rmd_pkg::status_type           status,
   output logic [31:0]                   digest_word
);

   logic [31:0] blk_mem_ff [rmd_pkg::NumWords];
   logic [31:0] rd_l_ff, rd_r_ff;
   logic [31:0] word_ff;
   logic [2:0]  left_ff;
   logic        last_ff;
   logic [5:0]  bib_ff;
   logic [31:0] blocks_ff;
   logic [63:0] len_ff;
   logic [31:0] chain_ff [5];
   logic [31:0] al_ff, bl_ff, cl_ff, dl_ff, el_ff;
   logic [31:0] ar_ff, br_ff, cr_ff, dr_ff, er_ff;
   logic [7:0]  byte_val;
   logic [2:0]  g_l, g_r;
   logic [31:0] t_l, t_r;

   // Byte that goes into the buffer this cycle.
   always_comb begin
      unique case (cmd.byte_src)
         rmd_pkg::PH_DATA: byte_val = word_ff[7:0];
         rmd_pkg::PH_PAD:  byte_val = 8'h80;
         rmd_pkg::PH_LEN:  byte_val = len_ff[7:0];
         default:          byte_val = 8'h00;
      endcase
   end

   // Buffer write of one byte lane, and the two registered round reads.
   always_ff @(posedge clock) begin
      if (cmd.put_byte) begin
         blk_mem_ff[bib_ff[5:2]][8*bib_ff[1:0] +: 8] <= byte_val;
      end
      rd_l_ff <= blk_mem_ff[rmd_pkg::sel_l(cmd.rd_round)];
      rd_r_ff <= blk_mem_ff[rmd_pkg::sel_r(cmd.rd_round)];
   end

   // Input word, remaining byte count and message length.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_data.data_word;
         left_ff <= (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;
         last_ff <= req_data.last_word;
      end else if (cmd.put_byte && cmd.byte_src == rmd_pkg::PH_DATA) begin
         word_ff <= word_ff >> 8;
         left_ff <= left_ff - 3'd1;
      end
      if (cmd.latch_len) begin
         len_ff <= {23'd0, blocks_ff, bib_ff, 3'd0};
      end else if (cmd.put_byte && cmd.byte_src == rmd_pkg::PH_LEN) begin
         len_ff <= len_ff >> 8;
      end
   end

   // Byte position in the block and count of finished blocks.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         bib_ff    <= '0;
         blocks_ff <= '0;
      end else if (cmd.put_byte) begin
         bib_ff <= bib_ff + 6'd1;
         if (bib_ff == rmd_pkg::LastByte) begin
            blocks_ff <= blocks_ff + 32'd1;
         end
      end
   end

   // One round of each line per cycle.
   always_comb begin
      g_l = cmd.round[6:4];
      g_r = 3'd4 - g_l;
      t_l = rmd_pkg::rotl(al_ff + rmd_pkg::mix(g_l, bl_ff, cl_ff, dl_ff) + rd_l_ff
                          + rmd_pkg::add_l(g_l), rmd_pkg::rot_l(cmd.round)) + el_ff;
      t_r = rmd_pkg::rotl(ar_ff + rmd_pkg::mix(g_r, br_ff, cr_ff, dr_ff) + rd_r_ff
                          + rmd_pkg::add_r(g_l), rmd_pkg::rot_r(cmd.round)) + er_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.init_work) begin
         al_ff <= chain_ff[0]; ar_ff <= chain_ff[0];
         bl_ff <= chain_ff[1]; br_ff <= chain_ff[1];
         cl_ff <= chain_ff[2]; cr_ff <= chain_ff[2];
         dl_ff <= chain_ff[3]; dr_ff <= chain_ff[3];
         el_ff <= chain_ff[4]; er_ff <= chain_ff[4];
      end else if (cmd.round_en) begin
         al_ff <= el_ff;
         el_ff <= dl_ff;
         dl_ff <= rmd_pkg::rotl(cl_ff, 4'd10);
         cl_ff <= bl_ff;
         bl_ff <= t_l;
         ar_ff <= er_ff;
         er_ff <= dr_ff;
         dr_ff <= rmd_pkg::rotl(cr_ff, 4'd10);
         cr_ff <= br_ff;
         br_ff <= t_r;
      end
   end

   // Chaining words: combine both lines at the end of a block.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= rmd_pkg::InitH[i];
         end
      end else if (cmd.update) begin
         chain_ff[0] <= chain_ff[1] + cl_ff + dr_ff;
         chain_ff[1] <= chain_ff[2] + dl_ff + er_ff;
         chain_ff[2] <= chain_ff[3] + el_ff + ar_ff;
         chain_ff[3] <= chain_ff[4] + al_ff + br_ff;
         chain_ff[4] <= chain_ff[0] + bl_ff + cr_ff;
      end
   end

   assign digest_word = (cmd.out_idx <= rmd_pkg::LastIdx) ? chain_ff[cmd.out_idx] : 32'd0;

   assign status.bytes_in_block  = bib_ff;
   assign status.bytes_left_zero = (left_ff == 3'd0);
   assign status.last_flag       = last_ff;

endmodule

`default_nettype wire

/* rtl/rmd_ctrl.sv */
// ----------------------------------------------------------------------------
// rmd_ctrl
// Sequencer: byte loading, padding, round stepping and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rmd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire rmd_pkg::status_type status,
   output rmd_pkg::cmd_type         cmd
);

   rmd_pkg::state_type state_ff, state_in;
   rmd_pkg::phase_type phase_ff, phase_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] len_cnt_ff, len_cnt_in;
   logic [2:0] out_ff, out_in;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rmd_pkg::ST_IDLE;
         phase_ff   <= rmd_pkg::PH_DATA;
         round_ff   <= '0;
         len_cnt_ff <= '0;
         out_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         round_ff   <= round_in;
         len_cnt_ff <= len_cnt_in;
         out_ff     <= out_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      round_in     = round_ff;
      len_cnt_in   = len_cnt_ff;
      out_in       = out_ff;
      cmd          = '0;
      cmd.byte_src = phase_ff;
      cmd.round    = round_ff;
      cmd.out_idx  = out_ff;
      unique case (state_ff)
         rmd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               phase_in = rmd_pkg::PH_DATA;
               state_in = rmd_pkg::ST_BYTE;
            end
         end
         rmd_pkg::ST_BYTE: begin
            unique case (phase_ff)
               rmd_pkg::PH_DATA: begin
                  if (!status.bytes_left_zero) begin
                     cmd.put_byte = 1'b1;
                  end else if (status.last_flag) begin
                     cmd.latch_len = 1'b1;
                     phase_in      = rmd_pkg::PH_PAD;
                  end else begin
                     state_in = rmd_pkg::ST_IDLE;
                  end
               end
               rmd_pkg::PH_PAD: begin
                  cmd.put_byte = 1'b1;
                  phase_in     = rmd_pkg::PH_ZERO;
               end
               rmd_pkg::PH_ZERO: begin
                  if (status.bytes_in_block == rmd_pkg::PadEnd) begin
                     phase_in   = rmd_pkg::PH_LEN;
                     len_cnt_in = '0;
                  end else begin
                     cmd.put_byte = 1'b1;
                  end
               end
               rmd_pkg::PH_LEN: begin
                  cmd.put_byte = 1'b1;
                  len_cnt_in   = len_cnt_ff + 3'd1;
                  if (len_cnt_ff == 3'd7) begin
                     phase_in = rmd_pkg::PH_DONE;
                  end
               end
               default: begin
                  out_in   = '0;
                  state_in = rmd_pkg::ST_OUT;
               end
            endcase
            // A full block goes to compression before the next byte.
            if (cmd.put_byte && status.bytes_in_block == rmd_pkg::LastByte) begin
               state_in = rmd_pkg::ST_PRIME;
            end
         end
         rmd_pkg::ST_PRIME: begin
            cmd.init_work = 1'b1;
            cmd.rd_round  = '0;
            round_in      = '0;
            state_in      = rmd_pkg::ST_ROUND;
         end
         rmd_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            cmd.rd_round = round_ff + 7'd1;
            round_in     = round_ff + 7'd1;
            if (round_ff == rmd_pkg::LastRound) begin
               state_in = rmd_pkg::ST_UPDATE;
            end
         end
         rmd_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            out_in     = '0;
            state_in   = (phase_ff == rmd_pkg::PH_DONE) ? rmd_pkg::ST_OUT : rmd_pkg::ST_BYTE;
         end
         rmd_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               if (out_ff == rmd_pkg::LastIdx) begin
                  cmd.clear = 1'b1;
                  state_in  = rmd_pkg::ST_IDLE;
               end else begin
                  out_in = out_ff + 3'd1;
               end
            end
         end
         default: state_in = rmd_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != rmd_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == rmd_pkg::ST_OUT);

   `RMD_ASSERT_NEXT(a_round_end, state_ff == rmd_pkg::ST_ROUND && round_ff == rmd_pkg::LastRound,
      state_ff == rmd_pkg::ST_UPDATE, "Round sequence did not end in the update step.")
   `RMD_ASSERT_NEXT(a_accept, req_valid && !req_stall,
      state_ff == rmd_pkg::ST_BYTE && phase_ff == rmd_pkg::PH_DATA,
      "Accepted word did not start byte loading.")
   `RMD_ASSERT_NEXT(a_digest_end, rsp_valid && !rsp_stall && out_ff == rmd_pkg::LastIdx,
      !rsp_valid && state_ff == rmd_pkg::ST_IDLE, "Digest output did not end after h4.")
   `RMD_ASSERT(a_out_range, !rsp_valid || out_ff <= rmd_pkg::LastIdx,
      "Digest word index out of range.")

endmodule

`default_nettype wire
